// ----- rtl/fmns_pkg.sv -----
// Shared constants, codes and types of the feature map nearest search block.
package fmns_pkg;

    // Map geometry
    localparam int MAP_SIDE = 128;
    localparam int MAP_LOG  = $clog2(MAP_SIDE);
    localparam int CELLS    = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W   = 2 * MAP_LOG;

    // Shared divider
    localparam int DIV_NW = 32;
    localparam int DIV_DW = 15;
    localparam int DIV_CW = $clog2(DIV_NW);

    typedef struct packed {
        logic              go;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    // Command modes
    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_CHECK  = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_LOADED = 2'd0;
    localparam logic [1:0] ST_FOUND  = 2'd1;
    localparam logic [1:0] ST_NONE   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_PA  = 3'd0;
    localparam logic [2:0] REG_PD  = 3'd1;
    localparam logic [2:0] REG_IW  = 3'd2;
    localparam logic [2:0] REG_IH  = 3'd3;
    localparam logic [2:0] REG_PPW = 3'd4;
    localparam logic [2:0] REG_PPH = 3'd5;

endpackage

// ----- rtl/fmns_div.sv -----
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module fmns_div import fmns_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_div_req          i_req,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo
);

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_quo;
    logic [DIV_DW:0]   n_sh;
    logic              n_ge;

    // Shift in the next dividend bit and trial subtract
    assign n_sh = {r_rem, r_quo[DIV_NW-1]};
    assign n_ge = n_sh >= {1'b0, r_den};

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.go && r_busy && (r_cnt == DIV_CW'(DIV_NW - 1));
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem <= '0;
            r_quo <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_ge ? DIV_DW'(n_sh - {1'b0, r_den}) : n_sh[DIV_DW-1:0];
            r_quo <= {r_quo[DIV_NW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ----- rtl/feature_map_nearest_search.sv -----
// Top level: feature map, used map, command sequencer, window scan and marking.
// Mode 0 load: the pixel bit is written and the finish state registers the strobe.
// Modes 1-3: 4 or 6 divisions on the shared divider, then for a search or query a
// scan of a W x W window (W = 42 or 32), then one cycle per marked pixel.
// One command at a time; busy is high from the start transfer until the result.
// After reset the 16384 used map pixels are cleared, one pixel a cycle, busy high;
// configuration writes are taken at any time. The receiver cannot stall results.
module feature_map_nearest_search import fmns_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [6:0]  i_pixel_x,
    input  logic [6:0]  i_pixel_y,
    input  logic        i_feature_bit,
    input  logic [5:0]  i_patch_col,
    input  logic [5:0]  i_patch_row,
    input  logic [17:0] i_loc_x,
    input  logic [17:0] i_loc_y,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [17:0] o_out_x,
    output logic [17:0] o_out_y,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);

    localparam int SW      = 26;
    localparam int D2W     = 48;
    localparam int WIN2    = MAP_SIDE / 3;
    localparam int WIN3    = MAP_SIDE / 4;
    localparam int WCW     = $clog2(WIN2);
    localparam int OUT_MAX = 262143;

    typedef logic signed [SW-1:0] t_sc;

    localparam t_sc MAP_S  = t_sc'(MAP_SIDE);
    localparam t_sc HALF_S = t_sc'(128);

    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DIV   = 5'd2;
    localparam logic [4:0] S_DIVW  = 5'd3;
    localparam logic [4:0] S_PREP  = 5'd4;
    localparam logic [4:0] S_CHK   = 5'd5;
    localparam logic [4:0] S_ROW   = 5'd6;
    localparam logic [4:0] S_SCAN  = 5'd7;
    localparam logic [4:0] S_DRAIN = 5'd8;
    localparam logic [4:0] S_POST  = 5'd9;
    localparam logic [4:0] S_POST2 = 5'd10;
    localparam logic [4:0] S_PSET  = 5'd11;
    localparam logic [4:0] S_MSET  = 5'd12;
    localparam logic [4:0] S_MARK  = 5'd13;
    localparam logic [4:0] S_MPIX  = 5'd14;
    localparam logic [4:0] S_FIN   = 5'd15;

    function automatic t_sc clamp_start(t_sc s, t_sc size, t_sc lo, t_sc hi);
        t_sc r;
        if (s < lo) r = lo;
        else if (s + size > hi) r = hi - size;
        else r = s;
        return r;
    endfunction

    function automatic t_sc trunc256(t_sc v);
        t_sc n;
        n = -v;
        return (v < 0) ? -(n >>> 8) : (v >>> 8);
    endfunction

    function automatic logic [17:0] sat18(t_sc v);
        logic [17:0] r;
        if (v < 0) r = '0;
        else if (v > t_sc'(OUT_MAX)) r = 18'(OUT_MAX);
        else r = v[17:0];
        return r;
    endfunction

    // Configuration registers
    logic [6:0]  r_pa, r_pd;
    logic [14:0] r_iw, r_ih, r_ppw, r_pph;

    // Command and sequencer state
    logic [4:0]        r_state;
    logic [1:0]        r_mode;
    logic [5:0]        r_col, r_row;
    logic [17:0]       r_lx, r_ly;
    logic [2:0]        r_di;
    logic [DIV_NW-1:0] r_dq [6];
    logic [ADDR_W-1:0] r_ccnt;

    // Geometry and scan
    t_sc                r_cx, r_cy, r_sx, r_sy;
    logic [MAP_LOG-1:0] r_mgx, r_mgy, r_wwx, r_wwy;
    logic [WCW-1:0]     r_wl, r_ix, r_iy;
    logic               r_chk;
    logic [D2W-1:0]     r_dx2, r_dy2, r_best;
    logic               r_s2v, r_found, r_far;
    logic [MAP_LOG-1:0] r_s2x, r_s2y, r_fx, r_fy;

    // Marking
    t_sc              r_rx0, r_ry0, r_rw, r_rh;
    logic [MAP_LOG:0] r_mcx, r_mcy, r_mxa, r_mxb, r_myb;

    // Result
    logic        r_strobe;
    logic [1:0]  r_status;
    logic [17:0] r_ox, r_oy;

    // Memories
    logic fmem [CELLS];
    logic umem [CELLS];
    logic r_fq, r_uq;

    // Combinational
    logic              accept;
    logic [6:0]        pa_n, pd_n;
    logic [14:0]       iw_n, ih_n;
    t_div_req          div_req;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;
    t_sc               sc_x, sc_y, m_op;
    logic              sc_in;
    logic signed [2*SW-1:0] m_prod;
    logic [D2W-1:0]    d2;
    logic              take;
    logic [ADDR_W-1:0] rd_addr, uw_addr, fw_addr;
    logic              uw_en, uw_d, fw_en;
    t_sc p_cx, p_cy, p_mgx, p_mgy, p_wwx, p_wwy, p_lox, p_loy, p_sx, p_sy;
    logic              p_chk;
    t_sc q_cx, q_cy, q_pp, q_f, q_wx, q_ux;
    logic [MAP_LOG-1:0]        q_fsel;
    logic [14:0]               q_isel;
    logic [MAP_LOG+DIV_DW:0]   q_prod;
    logic [MAP_LOG+DIV_DW+3:0] q_p8;
    logic [17:0]               q_out;
    t_sc m_xa, m_xb, m_ya, m_yb, m_xe, m_ye, k_x0, k_y0;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;

    assign pa_n = (r_pa == 7'd0) ? 7'd1 : r_pa;
    assign pd_n = (r_pd == 7'd0) ? 7'd1 : r_pd;
    assign iw_n = (r_iw < 15'd128) ? 15'd128 : r_iw;
    assign ih_n = (r_ih < 15'd128) ? 15'd128 : r_ih;

    // Select divider operands for the current step
    always_comb begin
        div_req.go  = (r_state == S_DIV);
        div_req.num = '0;
        div_req.den = DIV_DW'(1);
        if (r_mode == MODE_QUERY) begin
            unique case (r_di)
                3'd0: begin
                    div_req.num = DIV_NW'(r_lx) * DIV_NW'(MAP_SIDE * 16);
                    div_req.den = iw_n;
                end
                3'd1: begin
                    div_req.num = DIV_NW'(r_ly) * DIV_NW'(MAP_SIDE * 16);
                    div_req.den = ih_n;
                end
                3'd2: begin
                    div_req.num = DIV_NW'(r_ppw) * DIV_NW'(MAP_SIDE);
                    div_req.den = iw_n;
                end
                default: begin
                    div_req.num = DIV_NW'(r_pph) * DIV_NW'(MAP_SIDE);
                    div_req.den = ih_n;
                end
            endcase
        end else begin
            unique case (r_di)
                3'd0: begin
                    div_req.num = DIV_NW'({r_col, 1'b1}) * DIV_NW'(MAP_SIDE * 128);
                    div_req.den = DIV_DW'(pa_n);
                end
                3'd1: begin
                    div_req.num = DIV_NW'({r_row, 1'b1}) * DIV_NW'(MAP_SIDE * 128);
                    div_req.den = DIV_DW'(pd_n);
                end
                3'd2: begin
                    div_req.num = DIV_NW'(MAP_SIDE) - DIV_NW'(pa_n);
                    div_req.den = DIV_DW'({pa_n, 1'b0});
                end
                3'd3: begin
                    div_req.num = DIV_NW'(MAP_SIDE) - DIV_NW'(pd_n);
                    div_req.den = DIV_DW'({pd_n, 1'b0});
                end
                3'd4: begin
                    div_req.num = DIV_NW'(4 * MAP_SIDE);
                    div_req.den = DIV_DW'(pa_n) * DIV_DW'(5);
                end
                default: begin
                    div_req.num = DIV_NW'(4 * MAP_SIDE);
                    div_req.den = DIV_DW'(pd_n) * DIV_DW'(5);
                end
            endcase
        end
    end

    fmns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Scan position, shared squaring unit and compare against the best so far
    always_comb begin
        sc_x   = r_sx + t_sc'(r_ix);
        sc_y   = r_sy + t_sc'(r_iy);
        sc_in  = (sc_x >= 0) && (sc_x < MAP_S) && (sc_y >= 0) && (sc_y < MAP_S);
        m_op   = (r_state == S_ROW) ? (sc_y <<< 8) + HALF_S - r_cy
                                    : (sc_x <<< 8) + HALF_S - r_cx;
        m_prod = m_op * m_op;
        d2     = r_dx2 + r_dy2;
        take   = r_s2v && r_fq && !r_uq && (!r_found || (d2 < r_best));
    end

    // Memory addresses and write enables
    always_comb begin
        rd_addr = (r_state == S_SCAN)
                ? {sc_y[MAP_LOG-1:0], sc_x[MAP_LOG-1:0]}
                : {r_dq[1][MAP_LOG+7:8], r_dq[0][MAP_LOG+7:8]};
        fw_en   = accept && (i_mode == MODE_LOAD) && (32'(i_pixel_x) < MAP_SIDE)
                  && (32'(i_pixel_y) < MAP_SIDE);
        fw_addr = ADDR_W'(ADDR_W'(i_pixel_y) * ADDR_W'(MAP_SIDE) + ADDR_W'(i_pixel_x));
        uw_en   = 1'b0;
        uw_d    = 1'b0;
        uw_addr = fw_addr;
        priority if (r_state == S_CLEAR) begin
            uw_en   = 1'b1;
            uw_addr = r_ccnt;
        end else if (r_state == S_MARK) begin
            uw_en   = 1'b1;
            uw_d    = 1'b1;
            uw_addr = {r_mcy[MAP_LOG-1:0], r_mcx[MAP_LOG-1:0]};
        end else if (r_state == S_MPIX) begin
            uw_en   = 1'b1;
            uw_d    = 1'b1;
            uw_addr = {r_fy, r_fx};
        end else begin
            uw_en   = fw_en;
        end
    end

    // Store feature and used bits, registered reads
    always_ff @(posedge i_clk) begin
        if (fw_en) fmem[fw_addr] <= i_feature_bit;
        r_fq <= fmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (uw_en) umem[uw_addr] <= uw_d;
        r_uq <= umem[rd_addr];
    end

    // Derive margins, centers and search starts from the division results
    always_comb begin
        p_cx  = t_sc'(r_dq[0][SW-2:0]);
        p_cy  = t_sc'(r_dq[1][SW-2:0]);
        p_mgx = (r_dq[2] < DIV_NW'(4)) ? t_sc'(4) : t_sc'(r_dq[2][MAP_LOG-1:0]);
        p_mgy = (r_dq[3] < DIV_NW'(4)) ? t_sc'(4) : t_sc'(r_dq[3][MAP_LOG-1:0]);
        p_wwx = t_sc'(r_dq[4][MAP_LOG-1:0]);
        p_wwy = t_sc'(r_dq[5][MAP_LOG-1:0]);
        p_lox = t_sc'(r_dq[2][DIV_DW-1:1]);
        p_loy = t_sc'(r_dq[3][DIV_DW-1:1]);
        p_chk = !(((p_cx >>> 8) < p_mgx) || ((p_cx >>> 8) > MAP_S - p_mgx) ||
                  ((p_cy >>> 8) < p_mgy) || ((p_cy >>> 8) > MAP_S - p_mgy));
        if (r_mode == MODE_QUERY) begin
            p_sx = clamp_start(trunc256(p_cx - t_sc'(WIN3 * 128)), t_sc'(WIN3),
                               p_lox, MAP_S - p_lox);
            p_sy = clamp_start(trunc256(p_cy - t_sc'(WIN3 * 128)), t_sc'(WIN3),
                               p_loy, MAP_S - p_loy);
        end else begin
            p_sx = clamp_start((p_cx - t_sc'(WIN2 * 128) + HALF_S) >>> 8, t_sc'(WIN2),
                               p_mgx, MAP_S - p_mgx);
            p_sy = clamp_start((p_cy - t_sc'(WIN2 * 128) + HALF_S) >>> 8, t_sc'(WIN2),
                               p_mgy, MAP_S - p_mgy);
        end
    end

    // Post-search values; the second pass handles the y axis
    always_comb begin
        q_cx   = r_found ? (t_sc'(r_fx) <<< 8) + HALF_S : r_cx;
        q_cy   = r_found ? (t_sc'(r_fy) <<< 8) + HALF_S : r_cy;
        q_fsel = (r_state == S_POST2) ? r_fy : r_fx;
        q_isel = (r_state == S_POST2) ? ih_n : iw_n;
        q_pp   = (r_state == S_POST2) ? t_sc'(r_dq[3][DIV_DW-1:0])
                                      : t_sc'(r_dq[2][DIV_DW-1:0]);
        q_f    = t_sc'(q_fsel);
        q_wx   = ((q_pp <<< 1) + q_pp) >>> 2;
        q_ux   = q_f - (q_wx >>> 1);
        if (q_ux < 0) q_ux = '0;
        else if (q_ux + q_wx >= MAP_S) q_ux = MAP_S - q_wx;
        q_prod = {q_fsel, 1'b1} * q_isel;
        q_p8   = {q_prod, 3'b000};
        q_out  = sat18(t_sc'(q_p8 >> MAP_LOG));
    end

    // Patch window start and rectangle bounds inside the map
    always_comb begin
        k_x0 = clamp_start((r_cx >>> 8) - (t_sc'(r_wwx) >>> 1), t_sc'(r_wwx),
                           t_sc'(r_mgx), MAP_S - t_sc'(r_mgx));
        k_y0 = clamp_start((r_cy >>> 8) - (t_sc'(r_wwy) >>> 1), t_sc'(r_wwy),
                           t_sc'(r_mgy), MAP_S - t_sc'(r_mgy));
        m_xa = (r_rx0 < 0) ? '0 : r_rx0;
        m_ya = (r_ry0 < 0) ? '0 : r_ry0;
        m_xe = r_rx0 + r_rw;
        m_ye = r_ry0 + r_rh;
        m_xb = (m_xe > MAP_S) ? MAP_S : m_xe;
        m_yb = (m_ye > MAP_S) ? MAP_S : m_ye;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_ccnt   <= '0;
            r_strobe <= 1'b0;
            r_s2v    <= 1'b0;
            r_found  <= 1'b0;
            r_di     <= '0;
            r_pa     <= 7'd5;
            r_pd     <= 7'd5;
            r_iw     <= 15'd4096;
            r_ih     <= 15'd4096;
            r_ppw    <= 15'd512;
            r_pph    <= 15'd512;
        end else begin
            r_strobe <= (r_state == S_FIN);
            r_s2v    <= (r_state == S_SCAN) && sc_in;

            // Take configuration transfers
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_PA:  r_pa  <= i_cfg_data[6:0];
                    REG_PD:  r_pd  <= i_cfg_data[6:0];
                    REG_IW:  r_iw  <= i_cfg_data;
                    REG_IH:  r_ih  <= i_cfg_data;
                    REG_PPW: r_ppw <= i_cfg_data;
                    REG_PPH: r_pph <= i_cfg_data;
                    default: ;
                endcase
            end

            // Keep the nearest candidate
            if (take) begin
                r_found <= 1'b1;
                r_best  <= d2;
                r_fx    <= r_s2x;
                r_fy    <= r_s2y;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_ccnt <= r_ccnt + 1'b1;
                    if (r_ccnt == ADDR_W'(CELLS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_mode <= i_mode;
                        r_col  <= i_patch_col;
                        r_row  <= i_patch_row;
                        r_lx   <= i_loc_x;
                        r_ly   <= i_loc_y;
                        r_di   <= '0;
                        if (i_mode == MODE_LOAD) begin
                            r_status <= ST_LOADED;
                            r_ox     <= '0;
                            r_oy     <= '0;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: r_state <= S_DIVW;
                S_DIVW: begin
                    if (div_done) begin
                        r_dq[r_di] <= div_quo;
                        if (r_di == ((r_mode == MODE_QUERY) ? 3'd3 : 3'd5)) begin
                            r_state <= S_PREP;
                        end else begin
                            r_di    <= r_di + 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_PREP: begin
                    r_cx    <= p_cx;
                    r_cy    <= p_cy;
                    r_mgx   <= p_mgx[MAP_LOG-1:0];
                    r_mgy   <= p_mgy[MAP_LOG-1:0];
                    r_wwx   <= p_wwx[MAP_LOG-1:0];
                    r_wwy   <= p_wwy[MAP_LOG-1:0];
                    r_chk   <= p_chk;
                    r_sx    <= p_sx;
                    r_sy    <= p_sy;
                    r_wl    <= (r_mode == MODE_QUERY) ? WCW'(WIN3 - 1) : WCW'(WIN2 - 1);
                    r_ix    <= '0;
                    r_iy    <= '0;
                    r_found <= 1'b0;
                    r_far   <= 1'b0;
                    r_state <= (r_mode == MODE_CHECK) ? S_CHK : S_ROW;
                end
                S_CHK: begin
                    r_ox     <= sat18(r_cx);
                    r_oy     <= sat18(r_cy);
                    r_status <= (r_chk && r_fq) ? ST_FOUND : ST_NONE;
                    r_state  <= (r_chk && r_fq) ? S_PSET : S_FIN;
                end
                S_ROW: begin
                    r_dy2   <= m_prod[D2W-1:0];
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_dx2 <= m_prod[D2W-1:0];
                    r_s2x <= sc_x[MAP_LOG-1:0];
                    r_s2y <= sc_y[MAP_LOG-1:0];
                    if (r_ix == r_wl) begin
                        r_ix <= '0;
                        if (r_iy == r_wl) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_iy    <= r_iy + 1'b1;
                            r_state <= S_ROW;
                        end
                    end else begin
                        r_ix <= r_ix + 1'b1;
                    end
                end
                S_DRAIN: r_state <= S_POST;
                S_POST: begin
                    if (r_mode == MODE_SEARCH) begin
                        r_status <= r_found ? ST_FOUND : ST_NONE;
                        r_cx     <= q_cx;
                        r_cy     <= q_cy;
                        r_ox     <= sat18(q_cx);
                        r_oy     <= sat18(q_cy);
                        r_state  <= S_PSET;
                    end else begin
                        r_far <= (r_best >= D2W'(9 * 65536));
                        r_rx0 <= q_ux;
                        r_rw  <= q_wx;
                        if (r_found && (r_best >= D2W'(9 * 65536))) begin
                            r_status <= ST_FOUND;
                            r_ox     <= q_out;
                        end else begin
                            r_status <= ST_NONE;
                            r_ox     <= r_lx;
                            r_oy     <= r_ly;
                        end
                        r_state <= r_found ? S_POST2 : S_FIN;
                    end
                end
                S_POST2: begin
                    r_ry0 <= q_ux;
                    r_rh  <= q_wx;
                    if (r_far) r_oy <= q_out;
                    r_state <= S_MSET;
                end
                S_PSET: begin
                    r_rx0   <= k_x0;
                    r_ry0   <= k_y0;
                    r_rw    <= t_sc'(r_wwx);
                    r_rh    <= t_sc'(r_wwy);
                    r_state <= S_MSET;
                end
                S_MSET: begin
                    r_mxa <= m_xa[MAP_LOG:0];
                    r_mcx <= m_xa[MAP_LOG:0];
                    r_mcy <= m_ya[MAP_LOG:0];
                    r_mxb <= m_xb[MAP_LOG:0];
                    r_myb <= m_yb[MAP_LOG:0];
                    if ((m_xa < m_xb) && (m_ya < m_yb)) r_state <= S_MARK;
                    else r_state <= (r_mode == MODE_QUERY && r_far) ? S_MPIX : S_FIN;
                end
                S_MARK: begin
                    if (r_mcx + 1'b1 == r_mxb) begin
                        r_mcx <= r_mxa;
                        if (r_mcy + 1'b1 == r_myb) begin
                            r_state <= (r_mode == MODE_QUERY && r_far) ? S_MPIX : S_FIN;
                        end else begin
                            r_mcy <= r_mcy + 1'b1;
                        end
                    end else begin
                        r_mcx <= r_mcx + 1'b1;
                    end
                end
                S_MPIX: r_state <= S_FIN;
                S_FIN:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Results are single-cycle and never back to back
    a_strobe_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for two cycles");

    // Candidate stage is loaded only by a scan cycle
    a_s2v_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2v |-> ($past(r_state) == S_SCAN))
        else $error("candidate valid without a scan cycle");

    // Marking stays inside its rectangle
    a_mark_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MARK) |-> ((r_mcx < r_mxb) && (r_mcy < r_myb)))
        else $error("mark position outside rectangle");

    // Only defined status codes leave the block
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ((r_status == ST_LOADED) || (r_status == ST_FOUND) ||
                      (r_status == ST_NONE)))
        else $error("undefined status code");

    // No command is taken during the used map clear
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> (($past(r_ccnt) == ADDR_W'(CELLS - 1)) || busy))
        else $error("ready during used map clear");

endmodule
